[hw/rtl/upd_pkg.sv]
// shared types, codes and the hex digit helper function of the urlencoded pair decoder
`timescale 1ns / 1ps

package upd_pkg;

   // character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

   // event codes
   localparam logic [2:0] EV_BYTE       = 3'd0;
   localparam logic [2:0] EV_NAME_DONE  = 3'd1;
   localparam logic [2:0] EV_VALUE_DONE = 3'd2;
   localparam logic [2:0] EV_NAME_DROP  = 3'd3;
   localparam logic [2:0] EV_NO_VALUE   = 3'd4;

   // escape progress
   localparam logic [1:0] ESC_NONE   = 2'd0;
   localparam logic [1:0] ESC_FIRST  = 2'd1;
   localparam logic [1:0] ESC_SECOND = 2'd2;

   // register indexes
   localparam logic CSR_PAIR_SEPARATOR = 1'b0;
   localparam logic CSR_DECODE_ENABLE  = 1'b1;

   localparam logic [7:0] SEPARATOR_RESET = 8'd38;
   localparam logic       DECODE_RESET    = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       region_last;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       in_value_part;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] pair_separator;
      logic       decode_enable;
   } cfg_type;

   typedef struct packed {
      logic       value_phase;
      logic [1:0] escape_phase;
      logic [3:0] high_nibble;
   } dec_state_type;

   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // 'a'..'f' and 'A'..'F' share the low bits 1..6
         d = c[3:0] - 4'd1 + HEX_LETTER_BASE;
      end
      return d;
   endfunction

endpackage

[hw/rtl/upd_step.sv]
// per-byte decode: next state and the result one request gives
`timescale 1ns / 1ps

module upd_step
   import upd_pkg::*;
(
   input  req_payload_type req_in,
   input  dec_state_type   state_cur,
   input  cfg_type         cfg,
   output dec_state_type   state_nxt,
   output logic            has_result,
   output rsp_payload_type result
);

   logic          dec_got;
   logic [7:0]    dec_byte;
   dec_state_type dec_state;
   dec_state_type cleared;
   logic [7:0]    c;
   logic          last;

   assign c    = req_in.in_byte;
   assign last = req_in.region_last;

   // percent and plus decoding of a part byte
   always_comb begin
      dec_got   = 1'b1;
      dec_byte  = c;
      dec_state = state_cur;
      if (cfg.decode_enable) begin
         if (c == CH_PERCENT) begin
            dec_got = 1'b0;
            dec_state.escape_phase = ESC_FIRST;
         end else if (state_cur.escape_phase == ESC_FIRST) begin
            dec_got = 1'b0;
            dec_state.high_nibble  = hex_digit(c);
            dec_state.escape_phase = ESC_SECOND;
         end else if (state_cur.escape_phase == ESC_SECOND) begin
            dec_byte = {state_cur.high_nibble, hex_digit(c)};
            dec_state.escape_phase = ESC_NONE;
            dec_state.high_nibble  = 4'd0;
         end else if (c == CH_PLUS) begin
            dec_byte = CH_SPACE;
         end
      end
   end

   always_comb begin
      cleared              = state_cur;
      cleared.escape_phase = ESC_NONE;
      cleared.high_nibble  = 4'd0;

      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;

      if (!state_cur.value_phase) begin
         if (last) begin
            state_nxt        = cleared;
            has_result       = 1'b1;
            result.event_res = EV_NO_VALUE;
         end else if (c == CH_SPACE) begin
            state_nxt        = cleared;
            has_result       = 1'b1;
            result.event_res = EV_NAME_DROP;
         end else if (c == CH_EQUALS) begin
            state_nxt             = cleared;
            state_nxt.value_phase = 1'b1;
            has_result            = 1'b1;
            result.event_res      = EV_NAME_DONE;
         end else begin
            state_nxt         = dec_state;
            has_result        = dec_got;
            result.event_res  = EV_BYTE;
            result.byte_valid = 1'b1;
            result.data_byte  = dec_byte;
         end
      end else begin
         result.in_value_part = 1'b1;
         if (c == cfg.pair_separator) begin
            state_nxt             = cleared;
            state_nxt.value_phase = 1'b0;
            has_result            = 1'b1;
            result.event_res      = EV_VALUE_DONE;
         end else if (last) begin
            state_nxt             = cleared;
            state_nxt.value_phase = 1'b0;
            has_result            = 1'b1;
            result.event_res      = EV_VALUE_DONE;
            result.byte_valid     = dec_got;
            result.data_byte      = dec_got ? dec_byte : 8'd0;
         end else begin
            state_nxt         = dec_state;
            has_result        = dec_got;
            result.event_res  = EV_BYTE;
            result.byte_valid = 1'b1;
            result.data_byte  = dec_byte;
         end
      end
   end

endmodule

[hw/rtl/upd_out_stage.sv]
// result register that holds a response until the consumer takes it
`timescale 1ns / 1ps

module upd_out_stage
   import upd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_data,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

[hw/rtl/urlencoded_pair_decoder.sv]
// top level of the urlencoded name=value pair decoder
// a request accepted into the input register moves on to the result register,
// from which its response can be taken
// throughput: one request per cycle; a request that gives no response never waits
// a stalled response holds back the input register and then req_ready
// reset (synchronous, active high) empties both registers, returns to the name
// part with no escape pending, separator '&' and decoding on
`timescale 1ns / 1ps

module urlencoded_pair_decoder
   import upd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   // register writes
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [7:0]      csr_wdata
);

   // configuration registers
   logic [7:0] separator_ff;
   logic       decode_en_ff;
   cfg_type    cfg;

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // decoder state, advanced as each request leaves the input register
   dec_state_type state_ff;
   dec_state_type state_nxt;

   logic            has_result;
   rsp_payload_type result;
   logic            out_can_load;
   logic            advance;
   logic            req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RESET;
         decode_en_ff <= DECODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAIR_SEPARATOR: separator_ff <= csr_wdata;
            CSR_DECODE_ENABLE:  decode_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.pair_separator = separator_ff;
   assign cfg.decode_enable  = decode_en_ff;

   // request leaves the input register when it has no response or the
   // result register can take it
   assign advance   = in_valid_ff && (!has_result || out_can_load);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
   end

   upd_step u_step (
      .req_in     (in_data_ff),
      .state_cur  (state_ff),
      .cfg        (cfg),
      .state_nxt  (state_nxt),
      .has_result (has_result),
      .result     (result)
   );

   upd_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && has_result),
      .load_data   (result),
      .can_load    (out_can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/upd_checker.sv]
// port-level checks of the urlencoded pair decoder, bound to the top level
`timescale 1ns / 1ps

module upd_checker
   import upd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a decoded byte comes only with a plain byte or a value end
   a_byte_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_valid |->
         rsp_payload.event_res == EV_BYTE || rsp_payload.event_res == EV_VALUE_DONE)
      else $error("decoded byte on wrong event");

   // part flag of an event follows the event
   a_event_part: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res != EV_BYTE |->
         rsp_payload.in_value_part == (rsp_payload.event_res == EV_VALUE_DONE))
      else $error("event reports wrong part");

   // empty byte slot reads zero
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_valid |-> rsp_payload.data_byte == 8'd0)
      else $error("data byte set without byte valid");

endmodule

bind urlencoded_pair_decoder upd_checker u_upd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[tb/sv/tb_urlencoded_pair_decoder.sv]
// self-checking testbench of the urlencoded pair decoder
`timescale 1ns / 1ps

module tb_urlencoded_pair_decoder;
   import upd_pkg::*;

   // run limit in clock cycles, far above the slowest passing run
   localparam int CYCLE_LIMIT = 200000;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we      = 1'b0;
   logic            csr_index   = CSR_PAIR_SEPARATOR;
   logic [7:0]      csr_wdata   = '0;

   urlencoded_pair_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // decoder mirror: register copy and parse state, advanced per accepted request
   cfg_type         cfg_now;
   dec_state_type   mirror_state;
   rsp_payload_type decoded_queue[$];

   // bytes of the region being built by the random generator
   logic [7:0]      region_bytes[$];

   int  error_count   = 0;
   int  sent_count    = 0;
   int  cycle_count   = 0;
   // sender and receiver knobs: steady means no idling, hold is a forced stall
   bit  req_steady    = 1'b0;
   bit  rsp_steady    = 1'b0;
   int  rsp_hold_left = 0;

   // 50 MHz clock
   initial begin
      forever #10 clock = ~clock;
   end

   // hex digit value, anything that is not a hex digit counts as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);   // '0'..'9'
      if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);   // 'a'..'f'
      if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);   // 'A'..'F'
      return 4'd0;
   endfunction

   // percent and plus decoding of one part byte; 1 when a byte comes out
   function automatic bit unescape(input logic [7:0] c, output logic [7:0] d);
      d = '0;
      if (!cfg_now.decode_enable) begin
         // raw mode leaves any pending escape untouched
         d = c;
         return 1'b1;
      end
      if (c == CH_PERCENT) begin
         // a new percent restarts the escape
         mirror_state.escape_phase = ESC_FIRST;
         return 1'b0;
      end
      if (mirror_state.escape_phase == ESC_FIRST) begin
         mirror_state.high_nibble  = hex_value(c);
         mirror_state.escape_phase = ESC_SECOND;
         return 1'b0;
      end
      if (mirror_state.escape_phase == ESC_SECOND) begin
         d = {mirror_state.high_nibble, hex_value(c)};
         mirror_state.escape_phase = ESC_NONE;
         mirror_state.high_nibble  = '0;
         return 1'b1;
      end
      d = (c == CH_PLUS) ? CH_SPACE : c;
      return 1'b1;
   endfunction

   // one request through the mirror; 1 when it gives a response
   function automatic bit decode_request(input req_payload_type rq,
                                         output rsp_payload_type rs);
      logic [7:0] c;
      logic [7:0] d;
      bit         got;
      c  = rq.in_byte;
      rs = '0;
      if (!mirror_state.value_phase) begin
         // name part: last byte, space and equals win over decoding
         if (rq.region_last || c == CH_SPACE || c == CH_EQUALS) begin
            mirror_state.escape_phase = ESC_NONE;
            mirror_state.high_nibble  = '0;
            if (rq.region_last) begin
               rs.event_res = EV_NO_VALUE;
            end else if (c == CH_SPACE) begin
               rs.event_res = EV_NAME_DROP;
            end else begin
               rs.event_res = EV_NAME_DONE;
               mirror_state.value_phase = 1'b1;
            end
            return 1'b1;
         end
         got = unescape(c, d);
         rs.event_res  = EV_BYTE;
         rs.byte_valid = 1'b1;
         rs.data_byte  = d;
         return got;
      end
      rs.in_value_part = 1'b1;
      if (c == cfg_now.pair_separator) begin
         // separator closes the value without a byte, even as last byte
         mirror_state = '0;
         rs.event_res = EV_VALUE_DONE;
         return 1'b1;
      end
      got = unescape(c, d);
      if (rq.region_last) begin
         // last byte belongs to the value and closes it, byte or not
         mirror_state = '0;
         rs.event_res  = EV_VALUE_DONE;
         rs.byte_valid = got;
         rs.data_byte  = got ? d : 8'h00;
         return 1'b1;
      end
      rs.event_res  = EV_BYTE;
      rs.byte_valid = 1'b1;
      rs.data_byte  = d;
      return got;
   endfunction

   // offer one request from the falling edge, return right after its acceptance
   task automatic send_request(input req_payload_type rq);
      rsp_payload_type rs;
      @(negedge clock);
      while (!req_steady && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (!req_ready);
      if (decode_request(rq, rs)) decoded_queue.push_back(rs);
      sent_count++;
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      req_payload_type rq;
      for (int i = 0; i < s.len(); i++) begin
         rq.in_byte     = s[i];
         rq.region_last = last_at_end && (i == s.len() - 1);
         send_request(rq);
      end
   endtask

   // drop valid, drain all responses, then let a request with no response leave
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_PAIR_SEPARATOR) cfg_now.pair_separator = value;
      else cfg_now.decode_enable = value[0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // bytes that would end the current part early
   function automatic bit ends_part(input logic [7:0] c, input bit in_value);
      if (in_value) return c == cfg_now.pair_separator;
      return c == CH_SPACE || c == CH_EQUALS;
   endfunction

   function automatic void push_safe(input logic [7:0] c, input bit in_value);
      while (ends_part(c, in_value)) c = 8'($urandom_range(8'h61, 8'h7A));
      region_bytes.push_back(c);
   endfunction

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
   endfunction

   // one unit of part text: plain char, plus, good escape, bad escape or any byte
   function automatic void add_part_unit(input bit in_value);
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         push_safe(8'($urandom_range(8'h30, 8'h7A)), in_value);
      end else if (kind == 5) begin
         push_safe(CH_PLUS, in_value);
      end else if (kind <= 7) begin
         push_safe(CH_PERCENT, in_value);
         push_safe(hex_char($urandom_range(0, 15)), in_value);
         push_safe(hex_char($urandom_range(0, 15)), in_value);
      end else if (kind == 8) begin
         push_safe(CH_PERCENT, in_value);
         push_safe(8'($urandom_range(0, 255)), in_value);
         push_safe(8'($urandom_range(0, 255)), in_value);
      end else begin
         push_safe(8'($urandom_range(0, 255)), in_value);
      end
   endfunction

   // mostly well-formed regions of pairs, some cut short, some pure noise
   task automatic send_region();
      int              kind;
      int              n_pairs;
      int              cut;
      req_payload_type rq;
      kind = $urandom_range(0, 99);
      region_bytes.delete();
      if (kind < 13) begin
         repeat ($urandom_range(1, 6)) begin
            rq.in_byte     = 8'($urandom);
            rq.region_last = ($urandom_range(0, 3) == 0);
            send_request(rq);
         end
      end else begin
         n_pairs = $urandom_range(1, 3);
         for (int p = 0; p < n_pairs; p++) begin
            repeat ($urandom_range(1, 4)) add_part_unit(1'b0);
            region_bytes.push_back(CH_EQUALS);
            repeat ($urandom_range(0, 4)) add_part_unit(1'b1);
            if (p < n_pairs - 1) region_bytes.push_back(cfg_now.pair_separator);
         end
         cut = region_bytes.size();
         // broken region: ends at an arbitrary byte
         if (kind < 25) cut = $urandom_range(1, region_bytes.size());
         for (int i = 0; i < cut; i++) begin
            rq.in_byte     = region_bytes[i];
            rq.region_last = (i == cut - 1);
            send_request(rq);
         end
      end
   endtask

   task automatic send_random_regions(input int n_items);
      int start;
      start = sent_count;
      while (sent_count - start < n_items) send_region();
   endtask

   // reset settings: every event kind, escapes, field extremes, region ends
   task automatic test_directed_cases();
      req_payload_type rq;
      rq = '{in_byte: 8'h00, region_last: 1'b0};
      send_request(rq);
      rq.in_byte = 8'hFF;
      send_request(rq);
      send_text("%41 ", 1'b0);       // escaped name byte, then name dropped
      send_text("%z%6F&=", 1'b0);    // bad digit, restarted escape, '&' in name
      send_text(" =+%a&", 1'b0);     // space and '=' in value, escape cut by separator
      send_text("x", 1'b1);          // region ends in name part
      send_text(" ", 1'b1);
      send_text("=", 1'b1);
      send_text("=%", 1'b1);         // last byte of value gives no byte
      send_text("= ", 1'b1);         // trailing space closes value
      send_text("=&", 1'b1);         // separator as last byte
   endtask

   // separator and decode sweep, extremes included, back to reset values last
   task automatic test_separator_and_decode_settings();
      logic [7:0] seps [6] = '{8'h3B, 8'h00, 8'hFF, CH_EQUALS, CH_SPACE, SEPARATOR_RESET};
      // upper bits of the decode write are junk that must be ignored
      logic [7:0] decs [6] = '{8'h01, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h01};
      for (int i = 0; i < 6; i++) begin
         wait_for_idle();
         write_reg(CSR_PAIR_SEPARATOR, seps[i]);
         write_reg(CSR_DECODE_ENABLE, decs[i]);
         send_random_regions(75);
      end
   endtask

   // long stretch with no idling on either side
   task automatic test_back_to_back();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      send_random_regions(120);
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // receiver stalls for a long time while the sender keeps offering
   task automatic test_output_backpressure();
      req_steady    = 1'b1;
      rsp_hold_left = 150;
      send_random_regions(70);
      req_steady    = 1'b0;
   endtask

   // receiver: random stalls, forced hold counted down here
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 27);
         end
      end
   end

   // response check against the oldest expectation, field by field
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_queue.size() == 0) begin
            $error("response with none expected: %p", rsp_payload);
            error_count++;
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_payload.event_res !== want.event_res) begin
               $error("event_res expected %0d got %0d", want.event_res,
                      rsp_payload.event_res);
               error_count++;
            end
            if (rsp_payload.byte_valid !== want.byte_valid) begin
               $error("byte_valid expected %0b got %0b", want.byte_valid,
                      rsp_payload.byte_valid);
               error_count++;
            end
            if (rsp_payload.data_byte !== want.data_byte) begin
               $error("data_byte expected %02h got %02h", want.data_byte,
                      rsp_payload.data_byte);
               error_count++;
            end
            if (rsp_payload.in_value_part !== want.in_value_part) begin
               $error("in_value_part expected %0b got %0b", want.in_value_part,
                      rsp_payload.in_value_part);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("urlencoded_pair_decoder test failed");
         $finish;
      end
   end

   initial begin
      cfg_now.pair_separator = SEPARATOR_RESET;
      cfg_now.decode_enable  = DECODE_RESET;
      mirror_state           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_separator_and_decode_settings();
      test_back_to_back();
      test_output_backpressure();

      // drain, then wait for anything still in flight
      wait_for_idle();
      repeat (6) @(posedge clock);
      if (error_count == 0 && decoded_queue.size() == 0) begin
         $display("urlencoded_pair_decoder test passed");
      end else begin
         $display("urlencoded_pair_decoder test failed");
      end
      $finish;
   end

endmodule
